FILE: hdl/scancode_to_ascii_keyboard_fifo_top_defines.svh
// Assertion helpers for the keyboard decoder modules.
`ifndef SCANCODE_TO_ASCII_KEYBOARD_FIFO_TOP_DEFINES_SVH
`define SCANCODE_TO_ASCII_KEYBOARD_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/scd_pkg.sv
`timescale 1ns / 1ps

package scd_pkg;

    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CTRL   = 7'h1D;
    localparam logic [6:0] SC_ALT    = 7'h38;
    localparam logic [6:0] CASE_GAP  = 7'd32;
    localparam logic [6:0] CHAR_LO_A = 7'h61;
    localparam logic [6:0] CHAR_LO_Z = 7'h7A;

    typedef logic [RING_AW-1:0] t_ring_ptr;

    typedef struct packed {
        logic       func;
        logic [6:0] code;
        logic [6:0] ascii;
        logic       pressed;
        logic       shift;
        logic       ctrl;
        logic       alt;
        logic       event_mode;
        logic       do_push;
    } t_op;

    typedef struct packed {
        logic [6:0] key_code;
        logic [6:0] ascii_char;
        logic       key_pressed;
        logic       shift_held;
        logic       ctrl_held;
        logic       alt_held;
        logic       event_delivered;
        logic       push_dropped;
        logic [6:0] read_char;
        logic       read_empty;
    } t_result;

    function automatic t_ring_ptr ring_next(input t_ring_ptr p);
        return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : t_ring_ptr'(p + 1'b1);
    endfunction

    // US layout, scancode set 1, unshifted.
    function automatic logic [6:0] us_map(input logic [6:0] code);
        logic [6:0] ch;
        case (code)
            7'h01: ch = 7'h1B;
            7'h02: ch = 7'h31;
            7'h03: ch = 7'h32;
            7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;
            7'h06: ch = 7'h35;
            7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;
            7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39;
            7'h0B: ch = 7'h30;
            7'h0C: ch = 7'h2D;
            7'h0D: ch = 7'h3D;
            7'h0E: ch = 7'h08;
            7'h0F: ch = 7'h09;
            7'h10: ch = 7'h71;
            7'h11: ch = 7'h77;
            7'h12: ch = 7'h65;
            7'h13: ch = 7'h72;
            7'h14: ch = 7'h74;
            7'h15: ch = 7'h79;
            7'h16: ch = 7'h75;
            7'h17: ch = 7'h69;
            7'h18: ch = 7'h6F;
            7'h19: ch = 7'h70;
            7'h1A: ch = 7'h5B;
            7'h1B: ch = 7'h5D;
            7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h61;
            7'h1F: ch = 7'h73;
            7'h20: ch = 7'h64;
            7'h21: ch = 7'h66;
            7'h22: ch = 7'h67;
            7'h23: ch = 7'h68;
            7'h24: ch = 7'h6A;
            7'h25: ch = 7'h6B;
            7'h26: ch = 7'h6C;
            7'h27: ch = 7'h3B;
            7'h28: ch = 7'h27;
            7'h29: ch = 7'h60;
            7'h2B: ch = 7'h5C;
            7'h2C: ch = 7'h7A;
            7'h2D: ch = 7'h78;
            7'h2E: ch = 7'h63;
            7'h2F: ch = 7'h76;
            7'h30: ch = 7'h62;
            7'h31: ch = 7'h6E;
            7'h32: ch = 7'h6D;
            7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E;
            7'h35: ch = 7'h2F;
            7'h37: ch = 7'h2A;
            7'h39: ch = 7'h20;
            7'h4A: ch = 7'h2D;
            7'h4E: ch = 7'h2B;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: hdl/scd_front.sv
`timescale 1ns / 1ps

module scd_front import scd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_push,
    output logic       o_full,
    input  logic       i_func,
    input  logic [7:0] i_scan_byte,
    output logic       o_op_valid,
    output t_op        o_op,
    input  logic       i_op_pop
);

    logic       r_event_mode;
    logic       r_shift, r_ctrl, r_alt;
    logic       n_shift, n_ctrl, n_alt;
    t_op        r_q [2];
    logic       r_qwp, r_qrp;
    logic [1:0] r_qcnt;
    logic       w_accept;
    logic       w_pressed;
    logic [6:0] w_code;
    logic [6:0] w_base;
    logic [6:0] w_ascii;
    t_op        w_op;

    assign o_full     = (r_qcnt == 2'd2);
    assign w_accept   = i_push && !o_full;
    assign o_op_valid = (r_qcnt != 2'd0);
    assign o_op       = r_q[r_qrp];

    assign w_code    = i_scan_byte[6:0];
    assign w_pressed = ~i_scan_byte[7];

    always_comb begin
        n_shift = r_shift;
        n_ctrl  = r_ctrl;
        n_alt   = r_alt;
        if (i_func == FUNC_SCAN) begin
            if (w_code == SC_LSHIFT || w_code == SC_RSHIFT) begin
                n_shift = w_pressed;
            end else if (w_code == SC_CTRL) begin
                n_ctrl = w_pressed;
            end else if (w_code == SC_ALT) begin
                n_alt = w_pressed;
            end
        end
    end

    always_comb begin
        w_base  = us_map(w_code);
        w_ascii = w_base;
        if (n_shift && w_base >= CHAR_LO_A && w_base <= CHAR_LO_Z) begin
            w_ascii = w_base - CASE_GAP;
        end
        w_op.func       = i_func;
        w_op.code       = w_code;
        w_op.ascii      = w_ascii;
        w_op.pressed    = w_pressed;
        w_op.shift      = n_shift;
        w_op.ctrl       = n_ctrl;
        w_op.alt        = n_alt;
        w_op.event_mode = r_event_mode;
        w_op.do_push    = !r_event_mode && w_pressed && (w_ascii != 7'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_mode <= 1'b0;
            r_shift      <= 1'b0;
            r_ctrl       <= 1'b0;
            r_alt        <= 1'b0;
            r_qwp        <= 1'b0;
            r_qrp        <= 1'b0;
            r_qcnt       <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_event_mode <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_shift <= n_shift;
                r_ctrl  <= n_ctrl;
                r_alt   <= n_alt;
                r_qwp   <= ~r_qwp;
            end
            if (i_op_pop && o_op_valid) begin
                r_qrp <= ~r_qrp;
            end
            r_qcnt <= r_qcnt + {1'b0, w_accept} - {1'b0, i_op_pop && o_op_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q[r_qwp] <= w_op;
        end
    end

endmodule

FILE: hdl/scd_back.sv
`timescale 1ns / 1ps

`include "scancode_to_ascii_keyboard_fifo_top_defines.svh"

module scd_back import scd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_op_valid,
    input  t_op     i_op,
    output logic    o_op_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    logic [6:0]       r_ring [RING_DEPTH];
    t_ring_ptr        r_wptr, r_rptr;
    logic [6:0]       r_rd_data;
    logic             r_s2_valid;
    logic             r_s2_use_rd;
    t_result          r_s2;
    t_result          n_s2;
    t_result          r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_owp, r_orp;
    logic [OQ_CW-1:0] r_ocnt;
    logic             w_room;
    logic             w_issue;
    logic             w_ring_empty;
    logic             w_ring_full;
    logic             w_do_write;
    logic             w_do_read;
    logic             w_read_on_empty;
    logic             w_out_pop;
    t_result          w_s2_out;

    assign w_room       = (r_ocnt + OQ_CW'(r_s2_valid)) < OQ_CW'(OQ_DEPTH);
    assign w_issue      = i_op_valid && w_room;
    assign o_op_pop     = w_issue;
    assign w_ring_empty = (r_rptr == r_wptr);
    assign w_ring_full  = (ring_next(r_wptr) == r_rptr);
    assign w_do_write   = w_issue && (i_op.func == FUNC_SCAN) && i_op.do_push && !w_ring_full;
    assign w_do_read    = w_issue && (i_op.func == FUNC_READ) && !w_ring_empty;
    assign w_read_on_empty = w_issue && (i_op.func == FUNC_READ) && w_ring_empty;

    always_comb begin
        n_s2            = '0;
        n_s2.shift_held = i_op.shift;
        n_s2.ctrl_held  = i_op.ctrl;
        n_s2.alt_held   = i_op.alt;
        if (i_op.func == FUNC_SCAN) begin
            n_s2.key_code        = i_op.code;
            n_s2.ascii_char      = i_op.ascii;
            n_s2.key_pressed     = i_op.pressed;
            n_s2.event_delivered = i_op.event_mode;
            n_s2.push_dropped    = i_op.do_push && w_ring_full;
        end else begin
            n_s2.read_empty = w_ring_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_s2_valid <= 1'b0;
            r_owp      <= '0;
            r_orp      <= '0;
            r_ocnt     <= '0;
        end else begin
            r_s2_valid <= w_issue;
            if (w_do_write) begin
                r_wptr <= ring_next(r_wptr);
            end
            if (w_do_read) begin
                r_rptr <= ring_next(r_rptr);
            end
            if (r_s2_valid) begin
                r_owp <= r_owp + 1'b1;
            end
            if (w_out_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= r_ocnt + OQ_CW'(r_s2_valid) - OQ_CW'(w_out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_write) begin
            r_ring[r_wptr] <= i_op.ascii;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_read) begin
            r_rd_data <= r_ring[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s2        <= n_s2;
            r_s2_use_rd <= w_do_read;
        end
    end

    always_comb begin
        w_s2_out           = r_s2;
        w_s2_out.read_char = r_s2_use_rd ? r_rd_data : 7'd0;
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_oq[r_owp] <= w_s2_out;
        end
    end

    assign o_empty   = (r_ocnt == '0);
    assign w_out_pop = i_pop && !o_empty;
    assign o_result  = r_oq[r_orp];

    `SCD_ASSERT_IMPL(a_s2_has_room, i_clk, i_rst_n, r_s2_valid, r_ocnt < OQ_CW'(OQ_DEPTH))
    `SCD_ASSERT_NEXT(a_push_fills_ring, i_clk, i_rst_n, w_do_write, r_wptr != r_rptr)
    `SCD_ASSERT_NEXT(a_empty_read_holds, i_clk, i_rst_n, w_read_on_empty, $stable(r_rptr))
    `SCD_ASSERT_NEXT(a_empty_read_flag, i_clk, i_rst_n, w_read_on_empty, r_s2.read_empty)

endmodule

FILE: hdl/scancode_to_ascii_keyboard_fifo_top.sv
`timescale 1ns / 1ps

// Keyboard scancode decoder with a character buffer, set 1 codes, US layout.
// Requests enter through push/full with i_func and i_scan_byte: a scancode
// (func 0) updates the shift, ctrl and alt flags and is translated to ASCII;
// a read (func 1) pops one buffered character or reports the buffer empty.
// Every request yields exactly one result, delivered in order through
// empty/pop; the oldest result sits on the o_ ports while empty is low.
// i_cfg_we/i_cfg_wdata write the event mode bit; in buffer mode printable
// presses go into a 256-entry ring that keeps one slot free.
// Throughput is one request per cycle while full is low; decode happens as the
// request is queued, then the ring step and the result stage are each registered.
// When pop is held low, results collect in a four-entry output queue and a
// two-entry request queue; full rises once both are taken up.
// Reset clears the flags, the ring pointers, event mode and both queues.
module scancode_to_ascii_keyboard_fifo_top import scd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic       i_func,
    input  logic [7:0] i_scan_byte,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] o_key_code,
    output logic [6:0] o_ascii_char,
    output logic       o_key_pressed,
    output logic       o_shift_held,
    output logic       o_ctrl_held,
    output logic       o_alt_held,
    output logic       o_event_delivered,
    output logic       o_push_dropped,
    output logic [6:0] o_read_char,
    output logic       o_read_empty
);

    logic    w_op_valid;
    logic    w_op_pop;
    t_op     w_op;
    t_result w_result;

    scd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_func      (i_func),
        .i_scan_byte (i_scan_byte),
        .o_op_valid  (w_op_valid),
        .o_op        (w_op),
        .i_op_pop    (w_op_pop)
    );

    scd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .i_op       (w_op),
        .o_op_pop   (w_op_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (w_result)
    );

    assign o_key_code        = w_result.key_code;
    assign o_ascii_char      = w_result.ascii_char;
    assign o_key_pressed     = w_result.key_pressed;
    assign o_shift_held      = w_result.shift_held;
    assign o_ctrl_held       = w_result.ctrl_held;
    assign o_alt_held        = w_result.alt_held;
    assign o_event_delivered = w_result.event_delivered;
    assign o_push_dropped    = w_result.push_dropped;
    assign o_read_char       = w_result.read_char;
    assign o_read_empty      = w_result.read_empty;

endmodule

FILE: tb/scancode_to_ascii_keyboard_fifo_top_tb.sv
`timescale 1ns / 1ps

module scancode_to_ascii_keyboard_fifo_top_tb;
    import scd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_CAP = 40;
    localparam logic [6:0] NO_MOD = 7'h00;
    localparam logic REL_FLAG = 1'b1;
    localparam logic MAKE_FLAG = 1'b0;

    typedef struct {
        logic       func;
        logic [7:0] scan;
    } t_kb_req;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       i_func = 1'b0;
    logic [7:0] i_scan_byte = 8'h00;
    logic       empty;
    logic       pop = 1'b0;
    logic [6:0] o_key_code;
    logic [6:0] o_ascii_char;
    logic       o_key_pressed;
    logic       o_shift_held;
    logic       o_ctrl_held;
    logic       o_alt_held;
    logic       o_event_delivered;
    logic       o_push_dropped;
    logic [6:0] o_read_char;
    logic       o_read_empty;

    scancode_to_ascii_keyboard_fifo_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .push             (push),
        .full             (full),
        .i_func           (i_func),
        .i_scan_byte      (i_scan_byte),
        .empty            (empty),
        .pop              (pop),
        .o_key_code       (o_key_code),
        .o_ascii_char     (o_ascii_char),
        .o_key_pressed    (o_key_pressed),
        .o_shift_held     (o_shift_held),
        .o_ctrl_held      (o_ctrl_held),
        .o_alt_held       (o_alt_held),
        .o_event_delivered(o_event_delivered),
        .o_push_dropped   (o_push_dropped),
        .o_read_char      (o_read_char),
        .o_read_empty     (o_read_empty)
    );

    // Decoder state as the block should hold it.
    logic [6:0]  keymap [0:127];
    logic [6:0]  char_buf [0:RING_DEPTH-1];
    int unsigned buf_wr;
    int unsigned buf_rd;
    logic        shift_on;
    logic        ctrl_on;
    logic        alt_on;
    logic        event_mode;

    t_kb_req     pending_q[$];
    t_result     outcome_q[$];
    t_kb_req     next_req;
    t_result     got_r;
    t_result     want_r;
    logic        req_taken = 1'b0;
    int          send_gap = 0;
    int          pop_stall = 0;
    bit          calm = 1'b0;
    int          cycle_count = 0;
    int          mismatches = 0;
    int          queued_total = 0;
    int          accepted_total = 0;
    int          checked_total = 0;
    int          drop_total = 0;
    int          empty_read_total = 0;
    int          event_total = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(10, 40);
        end
    endfunction

    function automatic t_result decode_request(logic func, logic [7:0] scan);
        t_result     r;
        logic [6:0]  code;
        logic [6:0]  ch;
        logic        pressed;
        int unsigned nxt;
        r = '0;
        if (func == FUNC_SCAN) begin
            pressed = ~scan[7];
            code = scan[6:0];
            if (code == SC_LSHIFT || code == SC_RSHIFT) begin
                shift_on = pressed;
            end else if (code == SC_CTRL) begin
                ctrl_on = pressed;
            end else if (code == SC_ALT) begin
                alt_on = pressed;
            end
            ch = keymap[code];
            if (shift_on && ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
                ch = ch - CASE_GAP;
            end
            if (!event_mode && pressed && ch != 7'h00) begin
                nxt = (buf_wr + 1) % RING_DEPTH;
                if (nxt != buf_rd) begin
                    char_buf[buf_wr] = ch;
                    buf_wr = nxt;
                end else begin
                    r.push_dropped = 1'b1;
                end
            end
            r.key_code = code;
            r.ascii_char = ch;
            r.key_pressed = pressed;
            r.event_delivered = event_mode;
        end else if (buf_rd == buf_wr) begin
            r.read_empty = 1'b1;
        end else begin
            r.read_char = char_buf[buf_rd];
            buf_rd = (buf_rd + 1) % RING_DEPTH;
        end
        r.shift_held = shift_on;
        r.ctrl_held = ctrl_on;
        r.alt_held = alt_on;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("cycle %0d: %s mismatch, got %0h, expected %0h", cycle_count, what, got,
                     want);
        end
        mismatches++;
    endtask

    // Request driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || req_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                push <= 1'b0;
            end else if (pending_q.size() != 0) begin
                next_req = pending_q.pop_front();
                i_func <= next_req.func;
                i_scan_byte <= next_req.scan;
                push <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Result consumer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_stall > 0) begin
            pop_stall <= pop_stall - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            pop_stall <= pick_gap();
        end
    end

    // Monitor: checks results first, then predicts for the request taken at this edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            shift_on = 1'b0;
            ctrl_on = 1'b0;
            alt_on = 1'b0;
            event_mode = 1'b0;
            buf_wr = 0;
            buf_rd = 0;
        end else begin
            if (pop && !empty) begin
                got_r.key_code = o_key_code;
                got_r.ascii_char = o_ascii_char;
                got_r.key_pressed = o_key_pressed;
                got_r.shift_held = o_shift_held;
                got_r.ctrl_held = o_ctrl_held;
                got_r.alt_held = o_alt_held;
                got_r.event_delivered = o_event_delivered;
                got_r.push_dropped = o_push_dropped;
                got_r.read_char = o_read_char;
                got_r.read_empty = o_read_empty;
                if (outcome_q.size() == 0) begin
                    flag_mismatch("unrequested result", 8'h00, 8'h00);
                end else begin
                    want_r = outcome_q.pop_front();
                    checked_total++;
                    if (got_r.key_code !== want_r.key_code)
                        flag_mismatch("key_code", 8'(got_r.key_code), 8'(want_r.key_code));
                    if (got_r.ascii_char !== want_r.ascii_char)
                        flag_mismatch("ascii_char", 8'(got_r.ascii_char),
                                      8'(want_r.ascii_char));
                    if (got_r.key_pressed !== want_r.key_pressed)
                        flag_mismatch("key_pressed", 8'(got_r.key_pressed),
                                      8'(want_r.key_pressed));
                    if (got_r.shift_held !== want_r.shift_held)
                        flag_mismatch("shift_held", 8'(got_r.shift_held),
                                      8'(want_r.shift_held));
                    if (got_r.ctrl_held !== want_r.ctrl_held)
                        flag_mismatch("ctrl_held", 8'(got_r.ctrl_held), 8'(want_r.ctrl_held));
                    if (got_r.alt_held !== want_r.alt_held)
                        flag_mismatch("alt_held", 8'(got_r.alt_held), 8'(want_r.alt_held));
                    if (got_r.event_delivered !== want_r.event_delivered)
                        flag_mismatch("event_delivered", 8'(got_r.event_delivered),
                                      8'(want_r.event_delivered));
                    if (got_r.push_dropped !== want_r.push_dropped)
                        flag_mismatch("push_dropped", 8'(got_r.push_dropped),
                                      8'(want_r.push_dropped));
                    if (got_r.read_char !== want_r.read_char)
                        flag_mismatch("read_char", 8'(got_r.read_char), 8'(want_r.read_char));
                    if (got_r.read_empty !== want_r.read_empty)
                        flag_mismatch("read_empty", 8'(got_r.read_empty),
                                      8'(want_r.read_empty));
                    drop_total += int'(want_r.push_dropped);
                    empty_read_total += int'(want_r.read_empty);
                    event_total += int'(want_r.event_delivered);
                end
            end
            req_taken <= push && !full;
            if (push && !full) begin
                outcome_q.push_back(decode_request(i_func, i_scan_byte));
                accepted_total++;
            end
            if (i_cfg_we) begin
                event_mode = i_cfg_wdata;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("scancode_to_ascii_keyboard_fifo_top regression: fail");
            $finish;
        end
    end

    task automatic load_keys(int base, string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            keymap[base + i] = 7'(s[i]);
        end
    endtask

    task automatic add_req(logic func, logic [7:0] scan);
        t_kb_req r;
        r.func = func;
        r.scan = scan;
        pending_q.push_back(r);
        queued_total++;
    endtask

    task automatic wait_quiet();
        while (pending_q.size() != 0 || push || outcome_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_mode(logic m);
        wait_quiet();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [6:0] printable_code();
        logic [6:0] code;
        do begin
            code = 7'($urandom_range(1, 7'h58));
        end while (keymap[code] == 7'h00);
        return code;
    endfunction

    task automatic queue_random(int n, int read_pct, int noise_pct);
        int         stop_at;
        int         roll;
        logic [6:0] code;
        logic [6:0] modkey;
        stop_at = queued_total + n;
        while (queued_total < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < noise_pct) begin
                add_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else if (roll < noise_pct + read_pct) begin
                add_req(FUNC_READ, 8'($urandom_range(0, 255)));
            end else begin
                code = printable_code();
                case ($urandom_range(0, 7))
                    0, 1: modkey = SC_LSHIFT;
                    2: modkey = SC_RSHIFT;
                    3: modkey = SC_CTRL;
                    4: modkey = SC_ALT;
                    default: modkey = NO_MOD;
                endcase
                if (modkey != NO_MOD) add_req(FUNC_SCAN, {MAKE_FLAG, modkey});
                add_req(FUNC_SCAN, {MAKE_FLAG, code});
                if ($urandom_range(0, 3) != 0) add_req(FUNC_SCAN, {REL_FLAG, code});
                if (modkey != NO_MOD) add_req(FUNC_SCAN, {REL_FLAG, modkey});
            end
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < 128; i++) begin
            keymap[i] = 7'h00;
        end
        keymap[7'h01] = 7'h1B;
        load_keys(7'h02, "1234567890-=");
        keymap[7'h0E] = 7'h08;
        keymap[7'h0F] = 7'h09;
        load_keys(7'h10, "qwertyuiop[]");
        keymap[7'h1C] = 7'h0A;
        load_keys(7'h1E, "asdfghjkl;'");
        keymap[7'h29] = 7'h60;
        keymap[7'h2B] = 7'h5C;
        load_keys(7'h2C, "zxcvbnm,./");
        keymap[7'h37] = 7'h2A;
        keymap[7'h39] = 7'h20;
        keymap[7'h4A] = 7'h2D;
        keymap[7'h4E] = 7'h2B;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_mode(1'b0);
        add_req(FUNC_READ, 8'hFF);
        add_req(FUNC_SCAN, 8'h1E);
        add_req(FUNC_SCAN, {MAKE_FLAG, SC_LSHIFT});
        add_req(FUNC_SCAN, 8'h1E);
        add_req(FUNC_SCAN, 8'h02);
        add_req(FUNC_SCAN, {REL_FLAG, SC_LSHIFT});
        add_req(FUNC_SCAN, {MAKE_FLAG, SC_RSHIFT});
        add_req(FUNC_SCAN, 8'h2C);
        add_req(FUNC_SCAN, {REL_FLAG, SC_RSHIFT});
        add_req(FUNC_SCAN, {MAKE_FLAG, SC_CTRL});
        add_req(FUNC_SCAN, {MAKE_FLAG, SC_ALT});
        add_req(FUNC_SCAN, 8'h10);
        add_req(FUNC_SCAN, {REL_FLAG, SC_CTRL});
        add_req(FUNC_SCAN, {REL_FLAG, SC_ALT});
        add_req(FUNC_SCAN, 8'h90);
        add_req(FUNC_SCAN, 8'h00);
        add_req(FUNC_SCAN, 8'h59);
        add_req(FUNC_SCAN, 8'h5A);
        add_req(FUNC_SCAN, 8'h7F);
        add_req(FUNC_SCAN, 8'hFF);
        add_req(FUNC_SCAN, 8'h80);
        add_req(FUNC_SCAN, 8'h4E);
        add_req(FUNC_READ, 8'h00);

        set_mode(1'b1);
        add_req(FUNC_SCAN, 8'h1E);
        add_req(FUNC_READ, 8'hA5);
        add_req(FUNC_READ, 8'h5A);

        // Fill the buffer past capacity with bare presses so that pushes get dropped.
        set_mode(1'b0);
        calm = 1'b1;
        for (i = 0; i < 300; i++) begin
            add_req(FUNC_SCAN, {MAKE_FLAG, printable_code()});
        end

        set_mode(1'b1);
        calm = 1'b0;
        queue_random(150, 60, 10);

        set_mode(1'b0);
        queue_random(400, 35, 10);

        set_mode(1'b1);
        queue_random(120, 30, 30);

        set_mode(1'b0);
        calm = 1'b1;
        queue_random(150, 45, 5);
        wait_quiet();
        calm = 1'b0;
        queue_random(150, 45, 5);

        wait_quiet();
        repeat (8) @(negedge i_clk);
        if (outcome_q.size() != 0) begin
            flag_mismatch("missing results", 8'(outcome_q.size()), 8'h00);
        end
        $display("Checked %0d results from %0d requests in both modes.", checked_total,
                 accepted_total);
        $display("Seen %0d full-buffer drops, %0d empty reads and %0d event-mode scancodes.",
                 drop_total, empty_read_total, event_total);
        if (mismatches == 0) begin
            $display("scancode_to_ascii_keyboard_fifo_top regression: pass");
        end else begin
            $display("scancode_to_ascii_keyboard_fifo_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/scd_pkg.sv
hdl/scd_front.sv
hdl/scd_back.sv
hdl/scancode_to_ascii_keyboard_fifo_top.sv
tb/scancode_to_ascii_keyboard_fifo_top_tb.sv
